// ===== rtl/jdll_pkg.sv =====
// ----------------------------------------------------------------------------
// jdll_pkg: shared definitions for the least-loaded job dispatcher
// Field widths, worker count, function and status codes, register indices and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package jdll_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int WIDX        = $clog2(MAX_WORKERS);      // queue memory index
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);  // worker count width

  localparam int FUNC_W   = 2;
  localparam int JOB_W    = 16;
  localparam int WORKER_W = 4;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 16;
  localparam int WIU_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_SUBMIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE    = 2'd2;
  // Unused code: no state change, answered with the closed status.
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CPL_DONE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CPL_UNDER = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PENDING_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;
  localparam logic [WIU_W-1:0]   WIU_RESET   = 5'd16;

endpackage : jdll_pkg

`default_nettype wire

// ===== rtl/job_dispatch_least_loaded_unit.sv =====
// ----------------------------------------------------------------------------
// job_dispatch_least_loaded_unit: least-loaded job dispatcher
// Admits submits against a pending limit, assigns each admitted batch to the
// worker with the fewest queued batches, and retires completions.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                      Dir   Handshake
//   -------   ------------------------------------------   ---   ----------
//   input     func, job_count, worker                      in    valid/ready
//   output    status, chosen_worker, total_pending         out   valid/ready
//   config    cfg_index, cfg_data                          in    cfg_we only
//
// One item is in flight at a time. A refused submit, a close or an unused code
// goes from acceptance through the final step to a loaded result. A completion
// reads the queue memory at the accepting edge, writes the count back in its
// write-back step, and then loads the output register in the final step.
// An admitted submit first reduces the rotating pointer modulo the worker count
// by repeated subtract steps (0 to 15 of them), then scans the queue counts,
// reading 1 to the worker count of them, one per cycle from the single read
// port of the queue memory, then writes back and loads the result.
// Reset is synchronous and clears all control state; the queue memory is not
// swept, since a valid bit per entry makes an unwritten entry read as zero.
// A result waits in the output register while the sink stalls; the block then
// holds in its final step and takes no new item until the result is loaded.

`default_nettype none

module job_dispatch_least_loaded_unit
  import jdll_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic [JOB_W-1:0]      job_count,
  input  wire logic [WORKER_W-1:0]   worker,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic [WORKER_W-1:0]        chosen_worker,
  output logic [JOB_W-1:0]           total_pending,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MOD    = 6'b000010,
    S_SCAN   = 6'b000100,
    S_UPDATE = 6'b001000,
    S_CPL    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [LIMIT_W-1:0] pending_limit;
  logic [WIU_W-1:0]   workers_in_use;

  // Architectural state outside the memory.
  logic [JOB_W-1:0]   pending_total;
  logic [WIDX-1:0]    rotate_pointer;
  logic               open_flag;

  // Per-item working registers.
  logic [WIDX-1:0]     start;
  logic [WIDX-1:0]     cur;
  logic [WIDX-1:0]     cmp_cnt;
  logic [WIDX-1:0]     best;
  logic [JOB_W-1:0]    best_q;
  logic [WORKER_W-1:0] worker_q;
  logic                cpl_under;
  logic [STATUS_W-1:0] res_status;
  logic [WORKER_W-1:0] res_chosen;

  // Queue count memory with one valid bit per entry.
  logic [JOB_W-1:0]       qmem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] qvalid;
  logic [WIDX-1:0]        rd_addr;
  logic [JOB_W-1:0]       rd_data;
  logic                   rd_valid;
  logic                   mem_we;
  logic [WIDX-1:0]        wr_addr;
  logic [JOB_W-1:0]       wr_data;

  logic [CNT_W-1:0]  n_act;
  logic [JOB_W-1:0]  eff;
  logic              in_acc;
  logic              out_free;
  logic              over_limit;
  logic [WIDX-1:0]   next_cand;
  logic              take;
  logic [WIDX-1:0]   nb;
  logic [JOB_W-1:0]  nbq;
  logic              scan_last;
  logic              worker_in_range;
  logic              cpl_zero;
  logic [WIDX-1:0]   start_inc;

  // A worker count of zero acts as one, and anything above the memory depth
  // acts as the full depth.
  always_comb begin
    if (workers_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (CNT_W'(workers_in_use) > CNT_W'(MAX_WORKERS)) begin
      n_act = CNT_W'(MAX_WORKERS);
    end else begin
      n_act = CNT_W'(workers_in_use);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The limit test never sees a negative headroom: the second term matters
  // only when the total is within the limit.
  assign over_limit = (pending_total > pending_limit) ||
                      (job_count > (pending_limit - pending_total));

  // An entry never written reads as an empty queue.
  assign eff = rd_valid ? rd_data : '0;

  // Scan step: the memory output belongs to worker cur.
  assign take      = (cmp_cnt == '0) || (eff < best_q);
  assign nb        = take ? cur : best;
  assign nbq       = take ? eff : best_q;
  assign scan_last = (CNT_W'(cmp_cnt) == (n_act - CNT_W'(1))) || (nbq == '0);
  assign next_cand = ((CNT_W'(cur) + CNT_W'(1)) == n_act) ? '0 : WIDX'(cur + WIDX'(1));
  assign start_inc = ((CNT_W'(start) + CNT_W'(1)) == n_act) ? '0 : WIDX'(start + WIDX'(1));

  assign worker_in_range = (CNT_W'(worker_q) < CNT_W'(MAX_WORKERS));
  assign cpl_zero        = !worker_in_range || (eff == '0);

  // Read address: the completing worker at acceptance, the scan start while
  // the pointer is reduced, then the next candidate during the scan.
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = WIDX'(worker);
      S_MOD:   rd_addr = start;
      S_SCAN:  rd_addr = next_cand;
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = best;
    wr_data = (best_q == '1) ? best_q : best_q + JOB_W'(1);
    if (state == S_UPDATE) begin
      mem_we = 1'b1;
    end else if (state == S_CPL && !cpl_zero) begin
      mem_we  = 1'b1;
      wr_addr = WIDX'(worker_q);
      wr_data = eff - JOB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[wr_addr] <= wr_data;
    end
    rd_data  <= qmem[rd_addr];
    rd_valid <= qvalid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid <= '0;
    end else if (mem_we) begin
      qvalid[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_SUBMIT && job_count != '0 && open_flag && !over_limit) begin
            state_next = S_MOD;
          end else if (func == FUNC_COMPLETE) begin
            state_next = S_CPL;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MOD: begin
        if (CNT_W'(start) < n_act) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_FIN;
      S_CPL:    state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pending_limit  <= LIMIT_RESET;
      workers_in_use <= WIU_RESET;
      pending_total  <= '0;
      rotate_pointer <= '0;
      open_flag      <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_PENDING_LIMIT:  pending_limit  <= cfg_data[LIMIT_W-1:0];
          REG_WORKERS_IN_USE: workers_in_use <= cfg_data[WIU_W-1:0];
          default: ;
        endcase
      end

      // The output register fills at the end of an item and empties when the
      // sink takes the result; a new load wins when both meet in one cycle.
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (func == FUNC_SUBMIT && job_count != '0 && open_flag && !over_limit) begin
              pending_total <= pending_total + job_count;
            end else if (func == FUNC_COMPLETE) begin
              if (job_count > pending_total) begin
                pending_total <= '0;
              end else begin
                pending_total <= pending_total - job_count;
              end
            end else if (func == FUNC_CLOSE) begin
              open_flag <= 1'b0;
            end
          end
        end
        S_UPDATE: rotate_pointer <= start_inc;
        default: ;
      endcase
    end
  end

  // Working and payload registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        start    <= rotate_pointer;
        worker_q <= worker;
        cmp_cnt  <= '0;
        cpl_under  <= (job_count > pending_total);
        res_chosen <= '0;
        if (func == FUNC_SUBMIT) begin
          if (job_count == '0) begin
            res_status <= ST_ZERO;
          end else if (!open_flag) begin
            res_status <= ST_CLOSED;
          end else begin
            res_status <= ST_OVER;
          end
        end else begin
          res_status <= ST_CLOSED;
        end
      end
      S_MOD: begin
        if (CNT_W'(start) < n_act) begin
          cur <= start;
        end else begin
          start <= WIDX'(CNT_W'(start) - n_act);
        end
      end
      S_SCAN: begin
        best   <= nb;
        best_q <= nbq;
        if (!scan_last) begin
          cur     <= next_cand;
          cmp_cnt <= cmp_cnt + WIDX'(1);
        end
      end
      S_UPDATE: begin
        res_status <= ST_ACCEPTED;
        res_chosen <= WORKER_W'(best);
      end
      S_CPL: begin
        res_status <= (cpl_under || cpl_zero) ? ST_CPL_UNDER : ST_CPL_DONE;
        res_chosen <= worker_q;
      end
      S_FIN: begin
        if (out_free) begin
          status        <= res_status;
          chosen_worker <= res_chosen;
          total_pending <= pending_total;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("new item taken while one is in flight");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(cmp_cnt) < n_act) && (CNT_W'(cur) < n_act))
    else $error("scan ran past the active workers");

  a_mem_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_UPDATE) || (state == S_CPL))
    else $error("queue memory written outside write-back");

  a_limit_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ACCEPTED) |-> (total_pending <= pending_limit))
    else $error("admitted submit exceeds pending limit");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> out_valid && (state == S_IDLE))
    else $error("result not loaded at end of item");
`endif

endmodule : job_dispatch_least_loaded_unit

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the least-loaded job dispatcher
// Sends submits, completions, closes and unused codes through the input
// channel under several register settings and idle patterns. Every result is
// checked field by field against a cycle-free model of the dispatcher.
// ----------------------------------------------------------------------------

module testbench;
  import jdll_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog limit covers the longest item, the long receiver hold-off
  // and the worst random gaps on both sides many times over.
  localparam int unsigned QUIET_LIMIT       = 6000;
  localparam int unsigned LONG_STALL_CYCLES = 500;
  localparam int unsigned DRAIN_CYCLES      = 40;
  localparam int unsigned REPORT_MAX        = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [JOB_W-1:0]    count;
    logic [WORKER_W-1:0] worker;
  } job_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORKER_W-1:0] chosen;
    logic [JOB_W-1:0]    total;
  } dispatch_result_t;

  // Clock, reset and every input of the block start at known values.
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func          = '0;
  logic [JOB_W-1:0]      job_count     = '0;
  logic [WORKER_W-1:0]   worker        = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [WORKER_W-1:0]   chosen_worker;
  logic [JOB_W-1:0]      total_pending;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  job_dispatch_least_loaded_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .job_count     (job_count),
    .worker        (worker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .chosen_worker (chosen_worker),
    .total_pending (total_pending),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Items waiting to be sent, and the results the model predicts for items
  // that the block has already accepted, oldest first.
  job_item_t        job_backlog[$];
  dispatch_result_t predicted_replies[$];

  // Idle percentages for the current phase and the long hold-off request.
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  bit          long_stall_req  = 1'b0;
  bit          long_stall_done = 1'b0;
  int unsigned long_stall_cnt  = 0;

  // Set at each rising edge when the input channel moved an item.
  logic        job_taken = 1'b0;
  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;

  // Model copy of the dispatcher state and of its two registers.
  logic [JOB_W-1:0]   pending_sum;
  logic [JOB_W-1:0]   queue_depth [MAX_WORKERS];
  logic [WIDX-1:0]    rotate_ptr;
  bit                 submits_open;
  logic [LIMIT_W-1:0] limit_reg;
  logic [WIU_W-1:0]   workers_reg;
  // Number of workers that really take jobs; steers the completion targets.
  int unsigned        active_n;

  function automatic int unsigned effective_workers(logic [WIU_W-1:0] raw);
    int unsigned n;
    n = raw;
    if (n == 0) n = 1;
    if (n > MAX_WORKERS) n = MAX_WORKERS;
    return n;
  endfunction

  // Applies one item to the model state and returns the result it causes.
  function automatic dispatch_result_t predict_dispatch(job_item_t it);
    dispatch_result_t r;
    int unsigned n, start, best, best_q, cand, off;
    bit short_fall;
    r.status = ST_CLOSED;
    r.chosen = '0;
    if (it.func == FUNC_SUBMIT) begin
      // Zero size beats closed, and closed beats the limit test.
      if (it.count == '0) begin
        r.status = ST_ZERO;
      end else if (!submits_open) begin
        r.status = ST_CLOSED;
      end else if (pending_sum > limit_reg ||
                   int'(it.count) > int'(limit_reg) - int'(pending_sum)) begin
        r.status = ST_OVER;
      end else begin
        pending_sum = pending_sum + it.count;
        n = effective_workers(workers_reg);
        start = rotate_ptr % n;
        best = start;
        best_q = queue_depth[best];
        // Scan in rotation order; a strictly smaller count wins, and an
        // empty worker ends the scan at once.
        for (off = 1; off < n && best_q > 0; off++) begin
          cand = (start + off) % n;
          if (queue_depth[cand] < best_q) begin
            best = cand;
            best_q = queue_depth[cand];
          end
        end
        rotate_ptr = WIDX'((start + 1) % n);
        if (queue_depth[best] != '1) queue_depth[best] = queue_depth[best] + 1'b1;
        r.status = ST_ACCEPTED;
        r.chosen = WORKER_W'(best);
      end
    end else if (it.func == FUNC_COMPLETE) begin
      // Both the worker count and the pending total floor at zero; either
      // floor marks the completion as an underflow.
      short_fall = 1'b0;
      if (queue_depth[it.worker] == '0) short_fall = 1'b1;
      else queue_depth[it.worker] = queue_depth[it.worker] - 1'b1;
      if (it.count > pending_sum) begin
        short_fall = 1'b1;
        pending_sum = '0;
      end else begin
        pending_sum = pending_sum - it.count;
      end
      r.status = short_fall ? ST_CPL_UNDER : ST_CPL_DONE;
      r.chosen = it.worker;
    end else if (it.func == FUNC_CLOSE) begin
      submits_open = 1'b0;
    end
    // The unused code falls through with no state change and a closed status.
    r.total = pending_sum;
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // Driver: puts the next backlog item on the channel at the falling edge,
  // after the current one was taken, unless the sender idles this cycle.
  always @(negedge clk) begin : driver
    job_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || job_taken) begin
      if (job_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = job_backlog.pop_front();
        in_valid  <= 1'b1;
        func      <= nxt.func;
        job_count <= nxt.count;
        worker    <= nxt.worker;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // block fills up and holds its input low while the sender keeps offering.
  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      out_ready <= 1'b0;
      if (long_stall_cnt >= LONG_STALL_CYCLES) long_stall_done = 1'b1;
      else long_stall_cnt++;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result against the oldest prediction, predicts
  // each accepted item, and runs the watchdog.
  always @(posedge clk) begin : monitor
    dispatch_result_t want;
    job_item_t seen;
    if (rst) begin
      job_taken   <= 1'b0;
      quiet_count = 0;
    end else begin
      job_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          note_failure($sformatf("result with nothing pending: status %0d worker %0d total %0d",
                                 status, chosen_worker, total_pending));
        end else begin
          want = predicted_replies.pop_front();
          if (status !== want.status || chosen_worker !== want.chosen ||
              total_pending !== want.total) begin
            note_failure($sformatf(
              "mismatch: expected status %0d worker %0d total %0d, got %0d %0d %0d",
              want.status, want.chosen, want.total,
              status, chosen_worker, total_pending));
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.func   = func;
        seen.count  = job_count;
        seen.worker = worker;
        predicted_replies.insert(predicted_replies.size(), predict_dispatch(seen));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Register writes happen only while the block is idle, so the model copy
  // is updated right away.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PENDING_LIMIT) begin
      limit_reg = data[LIMIT_W-1:0];
    end else if (idx == REG_WORKERS_IN_USE) begin
      workers_reg = data[WIU_W-1:0];
      active_n = effective_workers(workers_reg);
    end
  endtask

  task automatic push_job(logic [FUNC_W-1:0] f, logic [JOB_W-1:0] c,
                          logic [WORKER_W-1:0] w);
    job_item_t it;
    it.func = f;
    it.count = c;
    it.worker = w;
    job_backlog.insert(job_backlog.size(), it);
  endtask

  // The sender pauses here until every item is sent and every result is in.
  task automatic wait_idle();
    while (job_backlog.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly submits and completions on active workers with sizes that keep
  // the pending total near the limit, with some noise: zero and full-range
  // sizes, completions on idle workers and the unused code.
  function automatic job_item_t random_job(int unsigned count_max);
    job_item_t it;
    int unsigned pick, sub;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    it.worker = WORKER_W'($urandom_range(0, MAX_WORKERS - 1));
    if (sub < 80) it.count = JOB_W'($urandom_range(1, count_max));
    else if (sub < 88) it.count = '0;
    else it.count = JOB_W'($urandom);
    if (pick < 56) begin
      it.func = FUNC_SUBMIT;
    end else if (pick < 97) begin
      it.func = FUNC_COMPLETE;
      if ($urandom_range(0, 99) < 85) it.worker = WORKER_W'($urandom_range(0, active_n - 1));
      if (sub < 80) it.count = JOB_W'($urandom_range(0, count_max));
    end else begin
      it.func = FUNC_RESERVED;
    end
    return it;
  endfunction

  task automatic run_phase(logic [LIMIT_W-1:0] lim, logic [WIU_W-1:0] wiu,
                           int unsigned send_pct, int unsigned recv_pct,
                           int unsigned n_items, int unsigned count_max,
                           bit with_close);
    int unsigned i;
    write_reg(REG_PENDING_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_WORKERS_IN_USE, CFG_DATA_W'(wiu));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n_items; i++) begin
      // Closing is permanent, so it only appears in the last phase.
      if (with_close && i == n_items / 3) push_job(FUNC_CLOSE, JOB_W'($urandom), '0);
      job_backlog.insert(job_backlog.size(), random_job(count_max));
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned i;
    pending_sum  = '0;
    rotate_ptr   = '0;
    submits_open = 1'b1;
    limit_reg    = LIMIT_RESET;
    workers_reg  = WIU_RESET;
    active_n     = effective_workers(WIU_RESET);
    for (i = 0; i < MAX_WORKERS; i++) queue_depth[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset register values: zero size, a fill to
    // exactly the limit, one past it, completions that floor the worker
    // count and the pending total, and the unused code.
    push_job(FUNC_SUBMIT,   16'd0,     4'd0);
    push_job(FUNC_SUBMIT,   16'd1,     4'd0);
    push_job(FUNC_SUBMIT,   16'd1024,  4'd0);
    push_job(FUNC_SUBMIT,   16'd1023,  4'd15);
    push_job(FUNC_SUBMIT,   16'd1,     4'd0);
    push_job(FUNC_COMPLETE, 16'd1,     4'd0);
    push_job(FUNC_COMPLETE, 16'd1,     4'd0);
    push_job(FUNC_COMPLETE, 16'hFFFF,  4'd5);
    push_job(FUNC_SUBMIT,   16'hFFFF,  4'd0);
    push_job(FUNC_RESERVED, 16'hFFFF,  4'd15);
    push_job(FUNC_COMPLETE, 16'd0,     4'd15);
    wait_idle();

    // A limit of zero refuses every nonzero size.
    write_reg(REG_PENDING_LIMIT, 16'd0);
    push_job(FUNC_SUBMIT, 16'd1, 4'd0);
    push_job(FUNC_SUBMIT, 16'd0, 4'd0);
    wait_idle();

    // Full limit with a single worker, then a full-size batch in and out.
    write_reg(REG_PENDING_LIMIT, 16'hFFFF);
    write_reg(REG_WORKERS_IN_USE, 16'd1);
    push_job(FUNC_SUBMIT,   16'hFFFF, 4'd0);
    push_job(FUNC_SUBMIT,   16'd1,    4'd0);
    push_job(FUNC_COMPLETE, 16'hFFFF, 4'd0);
    push_job(FUNC_COMPLETE, 16'd0,    4'd0);
    wait_idle();

    // A worker count of zero behaves as one.
    write_reg(REG_WORKERS_IN_USE, 16'd0);
    push_job(FUNC_SUBMIT, 16'd3, 4'd0);
    push_job(FUNC_SUBMIT, 16'd4, 4'd0);
    wait_idle();

    // Limit lowered below the pending total, then a count above the
    // worker range, which behaves as the full set.
    write_reg(REG_PENDING_LIMIT, 16'd5);
    push_job(FUNC_SUBMIT, 16'd1, 4'd0);
    wait_idle();
    write_reg(REG_PENDING_LIMIT, 16'd1024);
    write_reg(REG_WORKERS_IN_USE, 16'd31);
    push_job(FUNC_SUBMIT, 16'd2, 4'd0);
    push_job(FUNC_SUBMIT, 16'd2, 4'd0);
    wait_idle();

    // Random phases: idle patterns, register extremes and size ranges vary.
    run_phase(16'd1024, 5'd16, 0,  0,  300, 60,   1'b0);
    run_phase(16'd40,   5'd5,  88, 0,  250, 8,    1'b0);
    long_stall_req = 1'b1;
    run_phase(16'hFFFF, 5'd16, 0,  88, 300, 4000, 1'b0);
    run_phase(16'd1,    5'd1,  32, 32, 150, 2,    1'b0);
    run_phase(16'd500,  5'd31, 32, 32, 300, 40,   1'b0);
    run_phase(16'd200,  5'd0,  0,  0,  150, 30,   1'b0);
    run_phase(16'd1024, 5'd12, 32, 32, 300, 50,   1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_replies.size()));
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : testbench

// ===== files.f =====
rtl/jdll_pkg.sv
rtl/job_dispatch_least_loaded_unit.sv
dv/testbench.sv
